/* src/sac_pkg.sv */
package sac_pkg;

	localparam int WORD_BITS  = 16;
	localparam int FRAC_BITS  = 12;
	localparam int ANG_BITS   = WORD_BITS + 1;
	localparam int PROD_BITS  = 2 * ANG_BITS;
	localparam int PHASE_BITS = 32;
	localparam int Q_FRAC     = 30;
	localparam int Q_BITS     = Q_FRAC + 1;
	localparam int NUM_TERMS  = 4;

	// round(2^32 / 2pi) and round(2pi * 2^30)
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
	localparam logic [Q_BITS-1:0] Q30_ONE = Q_BITS'(1) << Q_FRAC;

	localparam int PHASE_LAT = 3;
	localparam int TRIG_LAT  = 16;

	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_SELECT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_C     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_D     = 3'd4;

	localparam logic [1:0] MAP_CLIFFORD = 2'd0;
	localparam logic [1:0] MAP_DE_JONG  = 2'd1;
	localparam logic [1:0] MAP_EXP_ONE  = 2'd2;
	localparam logic [1:0] MAP_EXP_TWO  = 2'd3;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] point_x;
		logic signed [WORD_BITS-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] next_x;
		logic signed [WORD_BITS-1:0] next_y;
	} result_t;

	typedef struct packed {
		logic              neg;
		logic [Q_BITS-1:0] mag;
	} trig_t;

endpackage

/* src/strange_attractor_map.sv */
// One step of a two-dimensional strange-attractor map on signed Q4.12 points:
// Clifford, de Jong or one of two experimental maps, chosen by map_select, with
// four signed Q4.12 coefficients. A point is taken on every clock edge where
// start is high; busy never rises, so one point per cycle is sustained. Its
// result shows on result for exactly one cycle, flagged by done, after one input
// register, three for the phase multiplier, sixteen for the sine/cosine series and
// three for coefficient scaling and the saturating sum. Four trig lanes run side by
// side. Results cannot be held off, so the receiver must take every done word.
// Write configuration only while no point is in flight.
module strange_attractor_map import sac_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  point_t                  point,
	output logic                    done,
	output result_t                 result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]    cfg_data
);

	localparam int TAG_DLY  = PHASE_LAT + TRIG_LAT;
	localparam int TERM_BITS = WORD_BITS + 2;
	localparam int SUM_BITS  = TERM_BITS + 1;
	localparam int TPROD_BITS = WORD_BITS + Q_BITS;
	localparam logic signed [ANG_BITS-1:0] ONE_F = ANG_BITS'(2 ** FRAC_BITS);
	localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(2 ** (WORD_BITS - 1) - 1);
	localparam logic signed [SUM_BITS-1:0] SAT_LO = -SUM_BITS'(2 ** (WORD_BITS - 1));

	typedef struct packed {
		logic                 want_cos;
		logic                 neg;
		logic [WORD_BITS-1:0] mag;
	} term_tag_t;

	logic [1:0]                  map_q;
	logic signed [WORD_BITS-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;

	logic signed [ANG_BITS-1:0] xe, ye, ae, be, ce, de;
	logic signed [ANG_BITS-1:0] m_n    [NUM_TERMS];
	logic signed [ANG_BITS-1:0] p_n    [NUM_TERMS];
	logic signed [ANG_BITS-1:0] coef_n [NUM_TERMS];
	logic                       cos_n  [NUM_TERMS];
	logic                       sub_n  [NUM_TERMS];
	term_tag_t                  tag_n  [NUM_TERMS];

	logic signed [ANG_BITS-1:0] m_s1   [NUM_TERMS];
	logic signed [ANG_BITS-1:0] p_s1   [NUM_TERMS];
	term_tag_t                  tag_s1 [NUM_TERMS];
	logic                       vld_s1;
	term_tag_t                  tag_dly_q [NUM_TERMS][TAG_DLY];
	logic [TAG_DLY-1:0]         vld_dly_q;

	logic [PHASE_BITS-1:0]      phase_w [NUM_TERMS];
	trig_t                      trig_w  [NUM_TERMS];

	logic [TPROD_BITS-1:0]         prod_s21 [NUM_TERMS];
	logic                          neg_s21  [NUM_TERMS];
	logic                          vld_s21;
	logic [TPROD_BITS-1:0]         rnd      [NUM_TERMS];
	logic [TERM_BITS-1:0]          rmag     [NUM_TERMS];
	logic signed [TERM_BITS-1:0]   val_s22  [NUM_TERMS];
	logic                          vld_s22;
	logic signed [SUM_BITS-1:0]    sum_x, sum_y;
	result_t                       result_s23;
	logic                          vld_s23;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q    <= MAP_CLIFFORD;
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAP_SELECT: map_q    <= cfg_data[1:0];
				CFG_COEF_A:     coef_a_q <= cfg_data;
				CFG_COEF_B:     coef_b_q <= cfg_data;
				CFG_COEF_C:     coef_c_q <= cfg_data;
				CFG_COEF_D:     coef_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign xe = ANG_BITS'($signed(point.point_x));
	assign ye = ANG_BITS'($signed(point.point_y));
	assign ae = ANG_BITS'(coef_a_q);
	assign be = ANG_BITS'(coef_b_q);
	assign ce = ANG_BITS'(coef_c_q);
	assign de = ANG_BITS'(coef_d_q);

	// lanes 0 and 1 build next_x, lanes 2 and 3 build next_y
	always_comb begin
		for (int i = 0; i < NUM_TERMS; i++) begin
			m_n[i]    = '0;
			p_n[i]    = '0;
			coef_n[i] = ONE_F;
			cos_n[i]  = 1'b0;
			sub_n[i]  = 1'b0;
		end
		unique case (map_q)
			MAP_CLIFFORD: begin
				m_n[0] = ae; p_n[0] = ye;
				m_n[1] = ae; p_n[1] = xe; coef_n[1] = ce; cos_n[1] = 1'b1;
				m_n[2] = be; p_n[2] = xe;
				m_n[3] = be; p_n[3] = ye; coef_n[3] = de; cos_n[3] = 1'b1;
			end
			MAP_DE_JONG: begin
				m_n[0] = ae; p_n[0] = ye;
				m_n[1] = be; p_n[1] = xe; cos_n[1] = 1'b1; sub_n[1] = 1'b1;
				m_n[2] = ce; p_n[2] = xe;
				m_n[3] = de; p_n[3] = ye; cos_n[3] = 1'b1; sub_n[3] = 1'b1;
			end
			MAP_EXP_ONE: begin
				m_n[0] = xe + ye; p_n[0] = ae; coef_n[0] = ce;
				m_n[1] = ye - xe; p_n[1] = be; coef_n[1] = de;
				cos_n[1] = 1'b1; sub_n[1] = 1'b1;
				m_n[2] = xe - ye; p_n[2] = ae; coef_n[2] = de; cos_n[2] = 1'b1;
				m_n[3] = ye + xe; p_n[3] = be; coef_n[3] = ce;
			end
			default: begin
				m_n[0] = ae + be; p_n[0] = ye; coef_n[0] = ce;
				m_n[1] = be - ae; p_n[1] = xe; coef_n[1] = de; cos_n[1] = 1'b1;
				m_n[2] = ce + de; p_n[2] = xe; coef_n[2] = ae;
				m_n[3] = de - ce; p_n[3] = ye; coef_n[3] = be;
				cos_n[3] = 1'b1; sub_n[3] = 1'b1;
			end
		endcase
		// a subtracted term is the same term with its coefficient sign flipped
		for (int i = 0; i < NUM_TERMS; i++) begin
			tag_n[i].want_cos = cos_n[i];
			tag_n[i].neg      = coef_n[i][ANG_BITS-1] ^ sub_n[i];
			tag_n[i].mag      = coef_n[i][ANG_BITS-1] ? WORD_BITS'(-coef_n[i])
				: WORD_BITS'(coef_n[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TERMS; i++) begin
			m_s1[i]         <= m_n[i];
			p_s1[i]         <= p_n[i];
			tag_s1[i]       <= tag_n[i];
			tag_dly_q[i][0] <= tag_s1[i];
			for (int k = 1; k < TAG_DLY; k++) begin
				tag_dly_q[i][k] <= tag_dly_q[i][k-1];
			end
		end
	end

	for (genvar g = 0; g < NUM_TERMS; g++) begin : g_lane
		sac_phase u_phase (
			.clk   (clk),
			.m     (m_s1[g]),
			.p     (p_s1[g]),
			.phase (phase_w[g])
		);
		sac_sincos u_trig (
			.clk      (clk),
			.phase    (phase_w[g]),
			.want_cos (tag_dly_q[g][PHASE_LAT-1].want_cos),
			.trig     (trig_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_dly_q <= '0;
			vld_s21   <= 1'b0;
			vld_s22   <= 1'b0;
			vld_s23   <= 1'b0;
		end else begin
			vld_s1    <= start && !busy;
			vld_dly_q <= {vld_dly_q[TAG_DLY-2:0], vld_s1};
			vld_s21   <= vld_dly_q[TAG_DLY-1];
			vld_s22   <= vld_s21;
			vld_s23   <= vld_s22;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_TERMS; i++) begin
			rnd[i]  = prod_s21[i] + (TPROD_BITS'(1) << (Q_FRAC - 1));
			rmag[i] = TERM_BITS'(rnd[i] >> Q_FRAC);
		end
		sum_x = SUM_BITS'(val_s22[0]) + SUM_BITS'(val_s22[1]);
		sum_y = SUM_BITS'(val_s22[2]) + SUM_BITS'(val_s22[3]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TERMS; i++) begin
			prod_s21[i] <= tag_dly_q[i][TAG_DLY-1].mag * trig_w[i].mag;
			neg_s21[i]  <= tag_dly_q[i][TAG_DLY-1].neg ^ trig_w[i].neg;
			val_s22[i]  <= neg_s21[i] ? -$signed(rmag[i]) : $signed(rmag[i]);
		end
		result_s23.next_x <= (sum_x > SAT_HI) ? WORD_BITS'(SAT_HI)
			: (sum_x < SAT_LO) ? WORD_BITS'(SAT_LO) : WORD_BITS'(sum_x);
		result_s23.next_y <= (sum_y > SAT_HI) ? WORD_BITS'(SAT_HI)
			: (sum_y < SAT_LO) ? WORD_BITS'(SAT_LO) : WORD_BITS'(sum_y);
	end

	assign done   = vld_s23;
	assign result = result_s23;

endmodule

/* src/sac_phase.sv */
module sac_phase import sac_pkg::*; (
	input  logic                        clk,
	input  logic signed [ANG_BITS-1:0]  m,
	input  logic signed [ANG_BITS-1:0]  p,
	output logic [PHASE_BITS-1:0]       phase
);

	localparam int KS        = 15;
	localparam int PART_BITS = PROD_BITS + KS + 1;
	localparam int FULL_BITS = PROD_BITS + 2 * KS;
	localparam logic [KS:0] K_LO = {1'b0, INV_TWO_PI[KS-1:0]};
	localparam logic [KS:0] K_HI = {1'b0, INV_TWO_PI[2*KS-1:KS]};

	logic signed [PROD_BITS-1:0] mp_s1;
	logic signed [PART_BITS-1:0] lo_s2;
	logic signed [PART_BITS-1:0] hi_s2;
	logic signed [FULL_BITS-1:0] full;
	logic [PHASE_BITS-1:0]       phase_s3;

	// angle times 1/2pi, split in two partial products
	assign full = FULL_BITS'(lo_s2) + (FULL_BITS'(hi_s2) <<< KS);

	always_ff @(posedge clk) begin
		mp_s1    <= m * p;
		lo_s2    <= mp_s1 * $signed(K_LO);
		hi_s2    <= mp_s1 * $signed(K_HI);
		phase_s3 <= full[2*FRAC_BITS +: PHASE_BITS];
	end

	assign phase = phase_s3;

endmodule

/* src/sac_step.sv */
module sac_step import sac_pkg::*; #(
	parameter int DIVISOR = 6
) (
	input  logic              clk,
	input  logic [Q_BITS-1:0] w,
	input  logic [Q_BITS-1:0] op,
	output logic [Q_BITS-1:0] res
);

	// exact floor division for any dividend below 2^Q_BITS
	localparam int SH = Q_BITS + $clog2(DIVISOR);
	localparam logic [32:0] RECIP = 33'((64'd1 << SH) / DIVISOR + 64'd1);

	logic [Q_BITS+32:0]   quot_full;
	logic [Q_BITS-1:0]    quot_s1;
	logic [Q_BITS-1:0]    op_s1;
	logic [2*Q_BITS-1:0]  prod_s2;
	logic [2*Q_BITS-1:0]  rnd;
	logic [Q_BITS-1:0]    res_s3;

	assign quot_full = w * RECIP;
	assign rnd       = prod_s2 + ((2 * Q_BITS)'(1) << (Q_FRAC - 1));

	always_ff @(posedge clk) begin
		quot_s1 <= Q_BITS'(quot_full >> SH);
		op_s1   <= op;
		prod_s2 <= op_s1 * (Q30_ONE - quot_s1);
		res_s3  <= Q_BITS'(rnd >> Q_FRAC);
	end

	assign res = res_s3;

endmodule

/* src/sac_sincos.sv */
module sac_sincos import sac_pkg::*; (
	input  logic                  clk,
	input  logic [PHASE_BITS-1:0] phase,
	input  logic                  want_cos,
	output trig_t                 trig
);

	localparam int RES_BITS = 30;
	localparam int DLY      = 9;
	localparam logic [RES_BITS-1:0] RES_HALF = RES_BITS'(1) << (RES_BITS - 1);

	typedef struct packed {
		logic [1:0] q;
		logic       xneg;
		logic       want_cos;
	} tag_t;

	typedef struct packed {
		logic [Q_BITS-1:0] x2;
		logic [Q_BITS-1:0] ux;
		tag_t              tag;
	} side_t;

	logic [PHASE_BITS-1:0]     sum_s1;
	logic                      cos_s1;
	logic [RES_BITS-1:0]       ur_s2;
	tag_t                      tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [RES_BITS+32:0]      xp_s3;
	logic [RES_BITS-1:0]       ux_s4, ux_s5, ux_s6;
	logic [2*RES_BITS-1:0]     xx_s5;
	logic [RES_BITS-1:0]       x2_s6;
	side_t                     side;
	side_t                     side_dly_q [DLY];
	logic [Q_BITS-1:0]         sin_w1, sin_w2, sin_mag;
	logic [Q_BITS-1:0]         cos_w1, cos_w2, cos_w3;
	logic [Q_BITS-1:0]         cos_val;
	tag_t                      tag_f;
	trig_t                     trig_n;
	trig_t                     trig_s16;

	always_ff @(posedge clk) begin
		// quadrant sits in the top bits once the phase is offset by an eighth turn
		sum_s1 <= phase + (PHASE_BITS'(1) << (PHASE_BITS - 3));
		cos_s1 <= want_cos;

		tag_s2.q        <= sum_s1[PHASE_BITS-1 -: 2];
		tag_s2.xneg     <= !sum_s1[RES_BITS-1];
		tag_s2.want_cos <= cos_s1;
		ur_s2 <= sum_s1[RES_BITS-1] ? RES_BITS'(sum_s1[RES_BITS-2:0])
			: RES_BITS'(RES_HALF - RES_BITS'(sum_s1[RES_BITS-2:0]));

		xp_s3  <= ur_s2 * TWO_PI_Q30;
		tag_s3 <= tag_s2;

		ux_s4  <= RES_BITS'((xp_s3 + ((RES_BITS + 33)'(1) << 31)) >> 32);
		tag_s4 <= tag_s3;

		xx_s5  <= ux_s4 * ux_s4;
		ux_s5  <= ux_s4;
		tag_s5 <= tag_s4;

		x2_s6  <= RES_BITS'((xx_s5 + ((2 * RES_BITS)'(1) << (Q_FRAC - 1))) >> Q_FRAC);
		ux_s6  <= ux_s5;
		tag_s6 <= tag_s5;
	end

	assign side.x2  = Q_BITS'(x2_s6);
	assign side.ux  = Q_BITS'(ux_s6);
	assign side.tag = tag_s6;

	always_ff @(posedge clk) begin
		side_dly_q[0] <= side;
		for (int k = 1; k < DLY; k++) begin
			side_dly_q[k] <= side_dly_q[k-1];
		end
	end

	// horner steps of the sine and cosine series
	sac_step #(.DIVISOR(42)) u_sin1 (.clk(clk), .w(side.x2), .op(side.x2), .res(sin_w1));
	sac_step #(.DIVISOR(20)) u_sin2 (.clk(clk), .w(sin_w1), .op(side_dly_q[2].x2),
		.res(sin_w2));
	sac_step #(.DIVISOR(6))  u_sin3 (.clk(clk), .w(sin_w2), .op(side_dly_q[5].ux),
		.res(sin_mag));

	sac_step #(.DIVISOR(56)) u_cos1 (.clk(clk), .w(side.x2), .op(side.x2), .res(cos_w1));
	sac_step #(.DIVISOR(30)) u_cos2 (.clk(clk), .w(cos_w1), .op(side_dly_q[2].x2),
		.res(cos_w2));
	sac_step #(.DIVISOR(12)) u_cos3 (.clk(clk), .w(cos_w2), .op(side_dly_q[5].x2),
		.res(cos_w3));

	assign tag_f   = side_dly_q[DLY-1].tag;
	assign cos_val = Q30_ONE - (cos_w3 >> 1);

	// quadrant swaps sine and cosine and sets the sign
	always_comb begin
		trig_n.mag = (tag_f.want_cos ^ tag_f.q[0]) ? cos_val : sin_mag;
		case (tag_f.q)
			2'd0: trig_n.neg = tag_f.want_cos ? 1'b0 : tag_f.xneg;
			2'd1: trig_n.neg = tag_f.want_cos ? !tag_f.xneg : 1'b0;
			2'd2: trig_n.neg = tag_f.want_cos ? 1'b1 : !tag_f.xneg;
			default: trig_n.neg = tag_f.want_cos ? tag_f.xneg : 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		trig_s16 <= trig_n;
	end

	assign trig = trig_s16;

endmodule

/* sim/tb_top.sv */
module tb_top;
	import sac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 22;
	localparam int N_RANDOM  = 1000;
	localparam int MAX_CYCLE = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	point_t point = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [WORD_BITS-1:0] cfg_data = '0;

	strange_attractor_map uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor's copy of the registers
	logic [1:0] sel_m;
	logic signed [WORD_BITS-1:0] ca, cb, cc, cd;
	result_t next_points[$];
	int errors = 0;
	int cycles = 0;

	// round half away from zero of a*b / 2^sh
	function automatic longint mul_round(longint a, longint b, int sh);
		logic neg;
		logic [127:0] p;
		longint r;
		neg = (a < 0) != (b < 0);
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		p = (p + (128'd1 << (sh - 1))) >> sh;
		r = longint'(p[63:0]);
		return neg ? -r : r;
	endfunction

	// phase in turns of m*p (Q24 radians), bits [24,56) of m*p*K
	function automatic logic [31:0] turns(longint m, longint p);
		logic signed [95:0] prod;
		prod = 96'(m) * 96'(p) * 96'(683565276);
		return prod[2*FRAC_BITS +: 32];
	endfunction

	function automatic void sin_cos(logic [31:0] ph, output longint sn, output longint cs);
		logic [1:0] quad;
		logic [31:0] rr;
		longint r, x, x2, t, u, s, c, one;
		one = 64'sd1 << 30;
		quad = 2'((({32'd0, ph} + 64'd536870912) >> 30) & 3);
		rr = ph - ({30'd0, quad} << 30);
		r = longint'(signed'(rr));
		x = mul_round(r, 64'sd6746518852, 32);
		x2 = mul_round(x, x, 30);
		t = one - x2 / 42;
		t = one - mul_round(x2, t, 30) / 20;
		t = one - mul_round(x2, t, 30) / 6;
		s = mul_round(x, t, 30);
		u = one - x2 / 56;
		u = one - mul_round(x2, u, 30) / 30;
		u = one - mul_round(x2, u, 30) / 12;
		c = one - mul_round(x2, u, 30) / 2;
		case (quad)
			2'd0: begin sn = s; cs = c; end
			2'd1: begin sn = c; cs = -s; end
			2'd2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endfunction

	function automatic longint sin_t(longint m, longint p);
		longint s, c;
		sin_cos(turns(m, p), s, c);
		return s;
	endfunction

	function automatic longint cos_t(longint m, longint p);
		longint s, c;
		sin_cos(turns(m, p), s, c);
		return c;
	endfunction

	function automatic logic signed [WORD_BITS-1:0] clamp(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return WORD_BITS'(v);
	endfunction

	function automatic result_t step_map(point_t pt);
		longint x, y, a, b, c, d, one, nx, ny;
		result_t res;
		x = pt.point_x; y = pt.point_y;
		a = ca; b = cb; c = cc; d = cd;
		one = 64'sd1 << FRAC_BITS;
		case (sel_m)
			MAP_CLIFFORD: begin
				nx = mul_round(one, sin_t(a, y), 30) + mul_round(c, cos_t(a, x), 30);
				ny = mul_round(one, sin_t(b, x), 30) + mul_round(d, cos_t(b, y), 30);
			end
			MAP_DE_JONG: begin
				nx = mul_round(one, sin_t(a, y), 30) - mul_round(one, cos_t(b, x), 30);
				ny = mul_round(one, sin_t(c, x), 30) - mul_round(one, cos_t(d, y), 30);
			end
			MAP_EXP_ONE: begin
				nx = mul_round(c, sin_t(x + y, a), 30) - mul_round(d, cos_t(y - x, b), 30);
				ny = mul_round(d, cos_t(x - y, a), 30) + mul_round(c, sin_t(y + x, b), 30);
			end
			default: begin
				nx = mul_round(c, sin_t(a + b, y), 30) + mul_round(d, cos_t(b - a, x), 30);
				ny = mul_round(a, sin_t(c + d, x), 30) - mul_round(b, cos_t(d - c, y), 30);
			end
		endcase
		res.next_x = clamp(nx);
		res.next_y = clamp(ny);
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (next_points.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				errors++;
			end else begin
				want = next_points.pop_front();
				if (result.next_x !== want.next_x || result.next_y !== want.next_y) begin
					$display("%0t: expected %h actual %h", $time, want, result);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAP_SELECT: sel_m = val[1:0];
			CFG_COEF_A: ca = val;
			CFG_COEF_B: cb = val;
			CFG_COEF_C: cc = val;
			CFG_COEF_D: cd = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (next_points.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_map(logic [1:0] m, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d);
		drain();
		write_reg(CFG_MAP_SELECT, {14'd0, m});
		write_reg(CFG_COEF_A, a);
		write_reg(CFG_COEF_B, b);
		write_reg(CFG_COEF_C, c);
		write_reg(CFG_COEF_D, d);
	endtask

	// random gap before each point, or none at all in burst mode
	task automatic send_point(point_t pt, bit burst, bit known, result_t ans);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		point <= pt;
		do @(posedge clk); while (busy);
		next_points.push_back(known ? ans : step_map(pt));
		@(negedge clk);
	endtask

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		bit known;
		logic [15:0] ex;
		logic [15:0] ey;
	} row_t;

	row_t rows[] = '{
		// all coefficients zero after reset: sin 0 = 0
		'{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
		'{16'h7fff, 16'h8000, 1, 16'h0000, 16'h0000},
		'{16'h8000, 16'h7fff, 1, 16'h0000, 16'h0000},
		'{16'h1000, 16'hf000, 0, 0, 0},
		'{16'h7fff, 16'h7fff, 0, 0, 0},
		'{16'h8000, 16'h8000, 0, 0, 0},
		'{16'h0001, 16'hffff, 0, 0, 0},
		'{16'h3243, 16'h1922, 0, 0, 0}
	};

	initial begin
		point_t pt;
		result_t ans;
		sel_m = MAP_CLIFFORD; ca = '0; cb = '0; cc = '0; cd = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			pt = {rows[i].x, rows[i].y};
			ans = {rows[i].ex, rows[i].ey};
			send_point(pt, 0, rows[i].known, ans);
		end
		// every map with extreme coefficients
		for (int m = 0; m < 4; m++) begin
			set_map(2'(m), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
			foreach (rows[i]) send_point({rows[i].x, rows[i].y}, 0, 0, '0);
		end
		// de Jong with zero coefficients gives -cos 0 = -1 on both
		set_map(MAP_DE_JONG, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_point({16'h1234, 16'h8000}, 0, 1, {16'hf000, 16'hf000});

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0) begin
				// typical attractor coefficients lie within about +-3
				if (n % 200 == 0)
					set_map(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
				else
					set_map(2'($urandom_range(0, 3)),
						16'($signed($urandom_range(0, 24576)) - 12288),
						16'($signed($urandom_range(0, 24576)) - 12288),
						16'($signed($urandom_range(0, 24576)) - 12288),
						16'($signed($urandom_range(0, 24576)) - 12288));
			end
			if (n == 500) begin
				// hold off until the pipe is empty
				start <= 1'b0;
				while (next_points.size() != 0) @(negedge clk);
			end
			pt = 32'($urandom);
			send_point(pt, (n / 50) % 3 == 0, 0, '0);
		end
		start <= 1'b0;
		while (next_points.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
